/* sv/mprp_pkg.sv */
// ----------------------------------------------------------------------------
// mprp_pkg
// Shared types, constants and the byte-wise CRC-16 step for the pulse
// response parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mprp_pkg;

    // frame layout
    localparam logic [4:0] FRAME_LEN   = 5'd17;
    localparam logic [4:0] COUNT_SAT   = 5'd18;
    localparam logic [4:0] HDR_ADDR    = 5'd0;
    localparam logic [4:0] HDR_FUNC    = 5'd1;
    localparam logic [4:0] HDR_BCNT    = 5'd2;
    localparam logic [4:0] PAYLOAD_LO  = 5'd3;
    localparam logic [4:0] PAYLOAD_END = 5'd15;
    localparam int         PAYLOAD_LEN = 12;

    // expected header bytes
    localparam logic [7:0] FUNC_READ_HOLD = 8'h03;
    localparam logic [7:0] BYTE_COUNT_VAL = 8'd12;

    // crc-16, reflected polynomial
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FRAME_ERR = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR   = 2'd2;

    // register map: slave address is register 0
    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;

    // slave address register reset
    localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pulse_ch0;
        logic signed [31:0] pulse_ch1;
        logic signed [31:0] pulse_ch2;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/modbus_pulse_response_parser_top.sv */
// ----------------------------------------------------------------------------
// modbus_pulse_response_parser_top
// Parses a read-holding-registers response byte by byte and reports status
// and three big-endian signed pulse counts at the end of each frame.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   -------  ---------  --------------------  ---------------------------------
//   in       sink       in_valid / in_stall   rx_byte, frame_end
//   out      source     out_valid / out_stall status, pulse_ch0..pulse_ch2
//   cfg      apb slave  psel/penable/pready   slave_addr at byte address 0
//
// - one byte per cycle while in_stall is low; crc step, header compare and result decode all sit
//   between the frame state registers and the output register
// - a result is registered into the output queue on the transfer of the frame's last byte
// - rst_n clears the counter, crc, header flag and output queue at once;
//   the payload store holds no reset and needs no clearing pass
// - the output register has a skid stage behind it, so input only stalls
//   when both are full
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_pulse_response_parser_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // byte input
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               frame_end,

    // result output
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      pulse_ch0,
    output logic signed [31:0]      pulse_ch1,
    output logic signed [31:0]      pulse_ch2,

    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [7:0]          slave_addr_reg;

    logic                in_accept;
    logic                push;
    logic                pop;
    mprp_pkg::result_t   res;

    logic                main_v_reg;
    logic                skid_v_reg;
    mprp_pkg::result_t   main_reg;
    mprp_pkg::result_t   skid_reg;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    // single register; writes ignore the lane bits, reads decode them
    assign prdata = (paddr == mprp_pkg::REG_SLAVE_ADDR) ? {24'd0, slave_addr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_addr_reg <= mprp_pkg::SLAVE_ADDR_RST;
        else if (psel && penable && pwrite && pready)
            slave_addr_reg <= pwdata[7:0];
    end

    // ---------------------------------------------------------------- frame
    // input stalls only when the skid stage is occupied
    assign in_stall  = skid_v_reg;
    assign in_accept = in_valid && !in_stall;

    mprp_frame u_frame
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .rx_byte      (rx_byte),
        .frame_end    (frame_end),
        .slave_addr   (slave_addr_reg),
        .result_valid (push),
        .result       (res)
    );

    // ---------------------------------------------------------------- output
    assign pop = main_v_reg && !out_stall;

    // main register feeds the port, skid catches a result while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_v_reg)
            begin
                main_v_reg <= 1'b1;
                skid_v_reg <= push;
            end
            else
                main_v_reg <= push;
        end
        else if (!main_v_reg)
            main_v_reg <= push;
        else if (push)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_v_reg)
            begin
                main_reg <= skid_reg;
                if (push)
                    skid_reg <= res;
            end
            else if (push)
                main_reg <= res;
        end
        else if (!main_v_reg)
        begin
            if (push)
                main_reg <= res;
        end
        else if (push)
            skid_reg <= res;
    end

    assign out_valid = main_v_reg;
    assign status    = main_reg.status;
    assign pulse_ch0 = main_reg.pulse_ch0;
    assign pulse_ch1 = main_reg.pulse_ch1;
    assign pulse_ch2 = main_reg.pulse_ch2;

    // ---------------------------------------------------------------- checks
    // skid holds data only behind a full main register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("skid stage valid with empty output register");

    // a frame end into an empty queue shows up next cycle
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && frame_end && !main_v_reg) |=> main_v_reg)
        else $error("frame result did not reach the output");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == mprp_pkg::STATUS_OK
                       || status == mprp_pkg::STATUS_FRAME_ERR
                       || status == mprp_pkg::STATUS_CRC_ERR))
        else $error("undefined status code on output");

    // pulse counts are zero on any error
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != mprp_pkg::STATUS_OK)
            |-> (pulse_ch0 == 32'sd0 && pulse_ch1 == 32'sd0 && pulse_ch2 == 32'sd0))
        else $error("nonzero pulse count with error status");

endmodule

`default_nettype wire

/* sv/mprp_frame.sv */
// ----------------------------------------------------------------------------
// mprp_frame
// Per-frame state: byte counter, running crc, header check and payload
// store. Produces the result of a frame on the transfer of its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mprp_frame
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              frame_end,
    input  wire logic [7:0]        slave_addr,
    output logic                   result_valid,
    output mprp_pkg::result_t      result
);

    logic [4:0]  count_reg;
    logic [4:0]  count_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        hdr_ok_reg;
    logic        hdr_ok_next;
    logic [7:0]  payload_reg [mprp_pkg::PAYLOAD_LEN];

    logic        mismatch;
    logic        pay_we;
    logic [3:0]  pay_idx;

    always_comb
    begin
        crc_next = mprp_pkg::crc_byte(crc_reg, rx_byte);
        mismatch = ((count_reg == mprp_pkg::HDR_ADDR) && (rx_byte != slave_addr))
                || ((count_reg == mprp_pkg::HDR_FUNC)
                    && (rx_byte != mprp_pkg::FUNC_READ_HOLD))
                || ((count_reg == mprp_pkg::HDR_BCNT)
                    && (rx_byte != mprp_pkg::BYTE_COUNT_VAL));
        hdr_ok_next = hdr_ok_reg && !mismatch;
        count_next  = (count_reg < mprp_pkg::COUNT_SAT) ? 5'(count_reg + 5'd1)
                                                        : count_reg;
        pay_we  = (count_reg >= mprp_pkg::PAYLOAD_LO)
               && (count_reg < mprp_pkg::PAYLOAD_END);
        pay_idx = 4'(count_reg - mprp_pkg::PAYLOAD_LO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 5'd0;
            crc_reg    <= mprp_pkg::CRC_INIT;
            hdr_ok_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                count_reg  <= 5'd0;
                crc_reg    <= mprp_pkg::CRC_INIT;
                hdr_ok_reg <= 1'b1;
            end
            else
            begin
                count_reg  <= count_next;
                crc_reg    <= crc_next;
                hdr_ok_reg <= hdr_ok_next;
            end
        end
    end

    // payload store, no reset
    always_ff @(posedge clk)
    begin
        if (accept && pay_we)
            payload_reg[pay_idx] <= rx_byte;
    end

    // result of the frame, length first, then crc residue, then header
    always_comb
    begin
        result_valid = accept && frame_end;
        result       = '0;
        if (count_next != mprp_pkg::FRAME_LEN)
            result.status = mprp_pkg::STATUS_FRAME_ERR;
        else if (crc_next != 16'h0000)
            result.status = mprp_pkg::STATUS_CRC_ERR;
        else if (!hdr_ok_next)
            result.status = mprp_pkg::STATUS_FRAME_ERR;
        else
        begin
            result.status    = mprp_pkg::STATUS_OK;
            result.pulse_ch0 = $signed({payload_reg[0], payload_reg[1],
                                        payload_reg[2], payload_reg[3]});
            result.pulse_ch1 = $signed({payload_reg[4], payload_reg[5],
                                        payload_reg[6], payload_reg[7]});
            result.pulse_ch2 = $signed({payload_reg[8], payload_reg[9],
                                        payload_reg[10], payload_reg[11]});
        end
    end

endmodule

`default_nettype wire

/* tb/modbus_pulse_response_parser_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_pulse_response_parser_top_tb
// Self-checking bench for the pulse response parser. Frames are built
// byte by byte (good responses, header and crc faults, short and overlong
// frames) and pushed through the byte channel with random gaps, while the
// result channel stalls at random. A local frame tracker predicts every
// result, and the monitor compares each result transfer field by field.
// ----------------------------------------------------------------------------

module modbus_pulse_response_parser_top_tb;

    // receiver hold-off used to fill the block up
    localparam int HOLD_CYCLES = 300;

    typedef enum
    {
        FR_GOOD,
        FR_BAD_ADDR,
        FR_BAD_FUNC,
        FR_BAD_BCNT,
        FR_BAD_CRC,
        FR_SHORT,
        FR_LONG,
        FR_RANDOM17
    } frame_kind_t;

    // dut ports
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               frame_end;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [31:0] pulse_ch0;
    logic signed [31:0] pulse_ch1;
    logic signed [31:0] pulse_ch2;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // frame tracker: our own copy of the parser state
    logic [7:0]         cfg_slave_addr;
    logic [4:0]         frame_count;
    logic [15:0]        track_crc;
    logic               header_good;
    logic [7:0]         payload_mem [mprp_pkg::PAYLOAD_LEN];
    mprp_pkg::result_t  expected_results [$];

    // byte transfers waiting for the driver, {frame_end, rx_byte}
    logic [8:0]         byte_q [$];
    logic [8:0]         next_byte;

    // handshake bookkeeping
    bit                 in_took;
    int                 in_gap;
    bit                 in_idle_en;
    bit                 out_idle_en;
    int                 stall_run;
    bit                 hold_req;
    int                 hold_cnt;

    // run statistics
    int                 errors;
    int                 items_queued;
    int                 results_checked;
    int                 n_ok;
    int                 n_frame_err;
    int                 n_crc_err;
    int                 addr_writes;

    modbus_pulse_response_parser_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .pulse_ch0 (pulse_ch0),
        .pulse_ch1 (pulse_ch1),
        .pulse_ch2 (pulse_ch2),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // crc-16 with the reflected polynomial, one bit at a time from the lsb
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ b[i];
            acc = {1'b0, acc[15:1]};
            if (fb)
                acc = acc ^ mprp_pkg::CRC_POLY;
        end
        return acc;
    endfunction

    // idle lengths: mostly none, often short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // pulse counts lean on the signed extremes
    function automatic logic [31:0] pick_count();
        int r;
        r = $urandom_range(0, 7);
        case (r)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR: result %0d %s: got %h, want %h", results_checked, what, got, want);
        errors++;
    endtask

    // advance the frame tracker by one accepted byte
    task automatic track_byte(input logic [7:0] b, input logic last);
        mprp_pkg::result_t r;
        track_crc = crc16_update(track_crc, b);
        // header bytes are judged on arrival, against the address as it stands now
        if (frame_count == mprp_pkg::HDR_ADDR)
        begin
            if (b != cfg_slave_addr)
                header_good = 1'b0;
        end
        else if (frame_count == mprp_pkg::HDR_FUNC)
        begin
            if (b != mprp_pkg::FUNC_READ_HOLD)
                header_good = 1'b0;
        end
        else if (frame_count == mprp_pkg::HDR_BCNT)
        begin
            if (b != mprp_pkg::BYTE_COUNT_VAL)
                header_good = 1'b0;
        end
        else if (frame_count >= mprp_pkg::PAYLOAD_LO && frame_count < mprp_pkg::PAYLOAD_END)
            payload_mem[frame_count - mprp_pkg::PAYLOAD_LO] = b;

        // counter sticks once past the frame length
        if (frame_count < mprp_pkg::COUNT_SAT)
            frame_count = frame_count + 5'd1;

        if (last)
        begin
            // length first, then crc residue, then header
            if (frame_count != mprp_pkg::FRAME_LEN)
                r.status = mprp_pkg::STATUS_FRAME_ERR;
            else if (track_crc != 16'h0000)
                r.status = mprp_pkg::STATUS_CRC_ERR;
            else if (!header_good)
                r.status = mprp_pkg::STATUS_FRAME_ERR;
            else
                r.status = mprp_pkg::STATUS_OK;

            if (r.status == mprp_pkg::STATUS_OK)
            begin
                r.pulse_ch0 = {payload_mem[0], payload_mem[1], payload_mem[2], payload_mem[3]};
                r.pulse_ch1 = {payload_mem[4], payload_mem[5], payload_mem[6], payload_mem[7]};
                r.pulse_ch2 = {payload_mem[8], payload_mem[9], payload_mem[10], payload_mem[11]};
                n_ok++;
            end
            else
            begin
                r.pulse_ch0 = '0;
                r.pulse_ch1 = '0;
                r.pulse_ch2 = '0;
                if (r.status == mprp_pkg::STATUS_CRC_ERR)
                    n_crc_err++;
                else
                    n_frame_err++;
            end
            expected_results.push_back(r);

            // next frame starts clean
            frame_count = '0;
            track_crc   = mprp_pkg::CRC_INIT;
            header_good = 1'b1;
        end
    endtask

    // compare one result transfer with the oldest prediction
    task automatic check_result();
        mprp_pkg::result_t want;
        if (expected_results.size() == 0)
            report_mismatch("transfer with no result pending", {30'd0, status}, '0);
        else
        begin
            want = expected_results.pop_front();
            if (status !== want.status)
                report_mismatch("status", {30'd0, status}, {30'd0, want.status});
            if (pulse_ch0 !== want.pulse_ch0)
                report_mismatch("pulse_ch0", pulse_ch0, want.pulse_ch0);
            if (pulse_ch1 !== want.pulse_ch1)
                report_mismatch("pulse_ch1", pulse_ch1, want.pulse_ch1);
            if (pulse_ch2 !== want.pulse_ch2)
                report_mismatch("pulse_ch2", pulse_ch2, want.pulse_ch2);
        end
        results_checked++;
    endtask

    // rising edge: note byte transfers for the driver, track them, check results
    always @(posedge clk)
    begin
        in_took = rst_n && in_valid && !in_stall;
        if (in_took)
            track_byte(rx_byte, frame_end);
        if (rst_n && out_valid && !out_stall)
            check_result();
    end

    // byte driver, falling edge; a held transfer keeps its payload
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_took))
        begin
            if (in_took)
                in_gap = in_idle_en ? gap_len() : 0;
            if (in_gap > 0 || byte_q.size() == 0)
            begin
                if (in_gap > 0)
                    in_gap--;
                // junk on the payload while nothing is offered
                in_valid  <= 1'b0;
                rx_byte   <= $urandom;
                frame_end <= $urandom_range(0, 1);
            end
            else
            begin
                next_byte = byte_q.pop_front();
                in_valid  <= 1'b1;
                rx_byte   <= next_byte[7:0];
                frame_end <= next_byte[8];
            end
        end
    end

    // result receiver, falling edge; the long hold-off is counted here
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else if (!out_idle_en)
            out_stall <= 1'b0;
        else if (stall_run > 0)
        begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_run = gap_len();
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // wait until every queued byte went in and every result came out
    task automatic wait_drained();
        while (byte_q.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        // a byte without end flag may still be in flight
        repeat (4) @(posedge clk);
    endtask

    // apb write of slave_addr, then a read back of the same register
    task automatic set_slave_addr(input logic [7:0] a);
        @(negedge clk);
        psel       = 1'b1;
        penable    = 1'b0;
        pwrite     = 1'b1;
        paddr      = mprp_pkg::REG_SLAVE_ADDR;
        pwdata     = $urandom;
        pwdata[7:0] = a;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cfg_slave_addr = a;
        addr_writes++;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== cfg_slave_addr)
        begin
            $display("ERROR: slave_addr read back %h, want %h", prdata[7:0], cfg_slave_addr);
            errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // build one frame and queue its bytes; with split_at > 0 the first
    // split_at bytes go in alone, then slave_addr changes before the rest
    task automatic queue_frame(input frame_kind_t kind, input int split_at,
                               input logic [7:0] split_addr);
        logic [7:0]  fb [$];
        logic [7:0]  v;
        logic [7:0]  m;
        logic [31:0] w;
        logic [15:0] c;
        int          n;
        int          k;
        fb = {};
        if (kind == FR_SHORT || kind == FR_LONG)
        begin
            if (kind == FR_SHORT)
                n = $urandom_range(1, 16);
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(30, 45);
            else
                n = $urandom_range(18, 20);
            for (k = 0; k < n; k++)
                fb.push_back($urandom);
            // half of them carry a proper header
            if ($urandom_range(0, 1) == 1)
            begin
                fb[0] = cfg_slave_addr;
                if (n > 1)
                    fb[1] = mprp_pkg::FUNC_READ_HOLD;
                if (n > 2)
                    fb[2] = mprp_pkg::BYTE_COUNT_VAL;
            end
        end
        else
        begin
            v = cfg_slave_addr;
            if (kind == FR_BAD_ADDR)
                v = v ^ 8'($urandom_range(1, 255));
            fb.push_back(v);
            v = mprp_pkg::FUNC_READ_HOLD;
            if (kind == FR_BAD_FUNC)
                v = v ^ 8'($urandom_range(1, 255));
            fb.push_back(v);
            v = mprp_pkg::BYTE_COUNT_VAL;
            if (kind == FR_BAD_BCNT)
                v = v ^ 8'($urandom_range(1, 255));
            fb.push_back(v);
            for (k = 0; k < 3; k++)
            begin
                w = pick_count();
                fb.push_back(w[31:24]);
                fb.push_back(w[23:16]);
                fb.push_back(w[15:8]);
                fb.push_back(w[7:0]);
            end
            // crc goes out low byte first, so a clean frame leaves residue zero
            c = mprp_pkg::CRC_INIT;
            for (k = 0; k < fb.size(); k++)
                c = crc16_update(c, fb[k]);
            fb.push_back(c[7:0]);
            fb.push_back(c[15:8]);
            if (kind == FR_BAD_CRC)
            begin
                // one flipped bit anywhere, header included
                k = $urandom_range(0, 16);
                m = 8'h01 << $urandom_range(0, 7);
                fb[k] = fb[k] ^ m;
            end
            else if (kind == FR_RANDOM17)
            begin
                for (k = 0; k < fb.size(); k++)
                    fb[k] = $urandom;
            end
        end

        for (k = 0; k < fb.size(); k++)
        begin
            if (split_at > 0 && k == split_at)
            begin
                wait_drained();
                set_slave_addr(split_addr);
            end
            byte_q.push_back({(k == fb.size() - 1), fb[k]});
            items_queued++;
        end
    endtask

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return FR_GOOD;
        else if (r < 63)
            return FR_BAD_ADDR;
        else if (r < 68)
            return FR_BAD_FUNC;
        else if (r < 73)
            return FR_BAD_BCNT;
        else if (r < 83)
            return FR_BAD_CRC;
        else if (r < 91)
            return FR_SHORT;
        else if (r < 96)
            return FR_LONG;
        else
            return FR_RANDOM17;
    endfunction

    // stimulus
    initial
    begin
        int         phase;
        int         target;
        logic [7:0] addr;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        frame_end = 1'b0;
        out_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        cfg_slave_addr = mprp_pkg::SLAVE_ADDR_RST;
        frame_count    = '0;
        track_crc      = mprp_pkg::CRC_INIT;
        header_good    = 1'b1;
        for (int i = 0; i < mprp_pkg::PAYLOAD_LEN; i++)
            payload_mem[i] = '0;

        in_gap      = 0;
        stall_run   = 0;
        hold_req    = 1'b0;
        hold_cnt    = 0;
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        errors      = 0;
        items_queued    = 0;
        results_checked = 0;
        n_ok        = 0;
        n_frame_err = 0;
        n_crc_err   = 0;
        addr_writes = 0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: a clean frame at the reset address
        queue_frame(FR_GOOD, 0, 8'h00);
        wait_drained();
        // directed: address byte judged before a mid-frame address change
        queue_frame(FR_GOOD, 1, 8'h00);
        wait_drained();

        // random phases, address at both extremes and random values
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: addr = 8'hFF;
                1: addr = $urandom;
                2: addr = 8'h00;
                default: addr = $urandom;
            endcase
            wait_drained();
            set_slave_addr(addr);

            // first phase runs back to back; the input idles in phases 1 and 3, the receiver stalls in the rest
            in_idle_en  = (phase == 1 || phase == 3);
            out_idle_en = (phase != 0);

            // long receiver hold-off while the sender keeps offering
            if (phase == 2)
                hold_req = 1'b1;

            target = items_queued + 115;
            while (items_queued < target)
                queue_frame(pick_kind(), 0, 8'h00);

            // sender pause until every result is back
            wait_drained();

            target = items_queued + 115;
            while (items_queued < target)
                queue_frame(pick_kind(), 0, 8'h00);
        end

        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d bytes, %0d results checked (ok %0d, frame error %0d, crc error %0d)",
                 items_queued, results_checked, n_ok, n_frame_err, n_crc_err);
        $display("slave address written %0d times, one receiver hold-off of %0d cycles",
                 addr_writes, HOLD_CYCLES);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("ERROR: timeout, %0d results still pending", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
